[rtl/core/wtpp_pkg.sv]
// shared types and constants for the windowed threshold peak picker
package wtpp_pkg;

    localparam int COUNT_BITS = 16;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t LENGTH_RESET = '1;

endpackage

[rtl/core/windowed_threshold_peak_picker.sv]
// sliding window local maximum peak picker with per-sample threshold
// a peak is registered into the output entry, or into the skid entry while the output entry holds a stalled peak
// throughput: one sample pair per cycle while sample_stall is low; a two-entry output buffer absorbs a peak_stall
// sample_stall rises only while both output entries hold undelivered peaks
// reset clears both windows, the sample counter and the output buffer
// and sets the stored signal length to 65535
module windowed_threshold_peak_picker
    import wtpp_pkg::*;
#(
    parameter int WINDOW_SIZE = 11,
    parameter int MIDDLE_POS  = 5,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               signal_length_we,
    input  logic [15:0]        signal_length,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] xcorr_sample,
    input  logic signed [15:0] threshold_sample,
    output logic               peak_valid,
    input  logic               peak_stall,
    output logic [15:0]        peak_location
);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    sample_t sample_win_reg [WINDOW_SIZE-1];
    sample_t sample_win_next [WINDOW_SIZE-1];
    sample_t thr_win_reg [MIDDLE_POS];
    sample_t thr_win_next [MIDDLE_POS];
    sample_t shifted_win [WINDOW_SIZE];
    sample_t xcorr_in;
    sample_t thr_in;
    sample_t mid_sample;
    sample_t mid_thr;

    count_t count_reg;
    count_t count_next;
    count_t count_inc;
    count_t length_reg;

    logic [WINDOW_SIZE-1:0] beaten;
    logic   window_full;
    logic   frame_end;
    logic   sample_xfer;
    logic   peak_xfer;
    logic   is_peak;
    count_t location;

    logic   out_valid_reg;
    logic   out_valid_next;
    count_t out_loc_reg;
    count_t out_loc_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    count_t skid_loc_reg;
    count_t skid_loc_next;

    assign xcorr_in    = SAMPLE_BITS'($unsigned(xcorr_sample));
    assign thr_in      = SAMPLE_BITS'($unsigned(threshold_sample));
    assign sample_xfer = sample_valid && !sample_stall;
    assign peak_xfer   = out_valid_reg && !peak_stall;

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (i == 0)
                shifted_win[i] = xcorr_in;
            else
                shifted_win[i] = sample_win_reg[i-1];
        end
    end

    assign mid_sample = sample_win_reg[MIDDLE_POS-1];
    assign mid_thr    = thr_win_reg[MIDDLE_POS-1];

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
            beaten[i] = (i != MIDDLE_POS) && (shifted_win[i] > mid_sample);
    end

    assign window_full = count_reg >= COUNT_BITS'(WINDOW_SIZE - 1);
    assign is_peak     = window_full && !(|beaten) && (mid_sample > mid_thr);
    assign location    = count_reg - COUNT_BITS'(MIDDLE_POS) + count_t'(1);
    assign count_inc   = count_reg + count_t'(1);
    assign frame_end   = (count_inc >= length_reg) || (count_inc == '0);

    // window shift and frame clear
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < WINDOW_SIZE - 1; i++)
            sample_win_next[i] = sample_win_reg[i];
        for (int i = 0; i < MIDDLE_POS; i++)
            thr_win_next[i] = thr_win_reg[i];
        if (sample_xfer)
        begin
            if (frame_end)
            begin
                count_next = '0;
                for (int i = 0; i < WINDOW_SIZE - 1; i++)
                    sample_win_next[i] = '0;
                for (int i = 0; i < MIDDLE_POS; i++)
                    thr_win_next[i] = '0;
            end
            else
            begin
                count_next = count_inc;
                for (int i = 0; i < WINDOW_SIZE - 1; i++)
                    sample_win_next[i] = shifted_win[i];
                for (int i = 0; i < MIDDLE_POS; i++)
                begin
                    if (i == 0)
                        thr_win_next[i] = thr_in;
                    else
                        thr_win_next[i] = thr_win_reg[i-1];
                end
            end
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_loc_next    = out_loc_reg;
        skid_valid_next = skid_valid_reg;
        skid_loc_next   = skid_loc_reg;
        if (!out_valid_reg || peak_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_loc_next    = skid_loc_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = sample_xfer && is_peak;
                out_loc_next   = location;
            end
        end
        else if (sample_xfer && is_peak)
        begin
            skid_valid_next = 1'b1;
            skid_loc_next   = location;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            length_reg     <= LENGTH_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
                sample_win_reg[i] <= '0;
            for (int i = 0; i < MIDDLE_POS; i++)
                thr_win_reg[i] <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (signal_length_we)
                length_reg <= signal_length;
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
                sample_win_reg[i] <= sample_win_next[i];
            for (int i = 0; i < MIDDLE_POS; i++)
                thr_win_reg[i] <= thr_win_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        out_loc_reg  <= out_loc_next;
        skid_loc_reg <= skid_loc_next;
    end

    assign sample_stall  = skid_valid_reg;
    assign peak_valid    = out_valid_reg;
    assign peak_location = out_loc_reg;

endmodule

[rtl/core/wtpp_checker.sv]
// port level checks for the windowed threshold peak picker and their bind
module wtpp_checker
    import wtpp_pkg::*;
#(
    parameter int WINDOW_SIZE = 11
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_stall,
    input logic        peak_valid,
    input logic        peak_stall,
    input logic [15:0] peak_location
);

    localparam int SEEN_BITS = $clog2(WINDOW_SIZE + 1);

    logic [SEEN_BITS-1:0] seen_reg;
    logic [SEEN_BITS-1:0] seen_next;

    // transfers since reset, saturating at the window size
    always_comb
    begin
        seen_next = seen_reg;
        if (sample_valid && !sample_stall && (seen_reg != SEEN_BITS'(WINDOW_SIZE)))
            seen_next = seen_reg + SEEN_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

    a_held_peak: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid && peak_stall |=> peak_valid && $stable(peak_location))
        else $error("stalled peak transfer changed");

    a_nonzero_loc: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid |-> peak_location != '0)
        else $error("peak location is zero");

    a_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid |-> seen_reg == SEEN_BITS'(WINDOW_SIZE))
        else $error("peak before the first window filled");

    a_stall_buffered: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> peak_valid)
        else $error("sample stall without a pending peak");

endmodule

bind windowed_threshold_peak_picker wtpp_checker #(.WINDOW_SIZE(WINDOW_SIZE)) u_wtpp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .peak_valid    (peak_valid),
    .peak_stall    (peak_stall),
    .peak_location (peak_location)
);
